// ----- src/ycl_pkg.sv -----
// ----------------------------------------------------------------------------
// YCbCr color likelihood package
// Shared types, register indexes, mode codes and the square root step.
// ----------------------------------------------------------------------------
package ycl_pkg;

  localparam int unsigned NUM_CFG_REGS = 5;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 8;

  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  // Register indexes.
  localparam cfg_idx_t REG_TARGET_LUMA        = 3'd0;
  localparam cfg_idx_t REG_TARGET_BLUE_CHROMA = 3'd1;
  localparam cfg_idx_t REG_TARGET_RED_CHROMA  = 3'd2;
  localparam cfg_idx_t REG_DISTANCE_MODE      = 3'd3;
  localparam cfg_idx_t REG_LUMA_GATE          = 3'd4;

  // Distance modes.
  typedef logic [1:0] mode_t;
  localparam mode_t MODE_EUCLID_YCBCR  = 2'd0;
  localparam mode_t MODE_GATED_CHROMA  = 2'd1;
  localparam mode_t MODE_CHROMA_L1     = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [7:0] RST_TARGET_LUMA        = 8'd0;
  localparam logic [7:0] RST_TARGET_BLUE_CHROMA = 8'd128;
  localparam logic [7:0] RST_TARGET_RED_CHROMA  = 8'd128;
  localparam mode_t      RST_DISTANCE_MODE      = MODE_EUCLID_YCBCR;
  localparam logic [7:0] RST_LUMA_GATE          = 8'd20;

  // Per-item side information that rides along the pipeline.
  typedef struct packed {
    mode_t      mode;
    logic       gate_fail;  // mode 1 luma difference above the gate
    logic       sat;        // squared distance at or above 2^16
    logic [7:0] l1_half;    // (|dCb| + |dCr|) / 2
  } side_t;

  typedef struct packed {
    logic [7:0] ady;
    logic [7:0] adb;
    logic [7:0] adr;
    side_t      side;
  } st_absdiff_t;

  typedef struct packed {
    logic [15:0] ysq;
    logic [15:0] bsq;
    logic [15:0] rsq;
    side_t       side;
  } st_square_t;

  typedef struct packed {
    logic [15:0] n;
    side_t       side;
  } st_sum_t;

  // Partial state of the digit-by-digit square root.
  typedef struct packed {
    logic [15:0] rem;
    logic [7:0]  root;
  } sqrt_t;

  localparam int unsigned SQRT_STAGES = 4;

  // One result bit of the restoring square root. The trial value is
  // (root + 2^i)^2 - root^2, where root holds only bits above i.
  function automatic sqrt_t sqrt_step(sqrt_t s, logic [2:0] bit_idx);
    logic [16:0] trial;
    logic [16:0] rem_ext;
    sqrt_t       r;
    trial   = ({9'd0, s.root} << ({1'b0, bit_idx} + 4'd1)) |
              (17'd1 << {bit_idx, 1'b0});
    rem_ext = {1'b0, s.rem};
    r       = s;
    if (rem_ext >= trial) begin
      r.rem  = 16'(rem_ext - trial);
      r.root = s.root | (8'd1 << bit_idx);
    end
    return r;
  endfunction

endpackage

// ----- src/ycbcr_color_likelihood_unit.sv -----
// ----------------------------------------------------------------------------
// YCbCr color likelihood unit
// Scores how close a YCbCr pixel lies to a configured target color.
// ----------------------------------------------------------------------------
// The unit accepts one pixel per clock while the output side does not stall
// and returns one 8-bit likelihood per pixel, in order. The work runs through
// eight register stages: absolute differences, squares, sum and range check,
// four square root stages that each resolve two root bits, and the output
// register. Every stage carries its own valid bit and accepts a new item
// whenever it is empty or its successor moves, so bubbles close up and a
// stall at the output backs up stage by stage without losing or repeating a
// pixel. Throughput is one pixel per cycle while the output does not stall,
// set by the fully pipelined square root. Configuration registers
// are written through the cfg port in a single cycle and must only be changed
// while no pixel is in flight.
module ycbcr_color_likelihood_unit (
  input  logic               clk,
  input  logic               rst_n,
  // Configuration write port.
  input  logic               cfg_we,
  input  ycl_pkg::cfg_idx_t  cfg_index,
  input  ycl_pkg::cfg_data_t cfg_wdata,
  // Pixel input channel.
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_luma,
  input  logic [7:0]         in_blue_chroma,
  input  logic [7:0]         in_red_chroma,
  // Likelihood output channel.
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_likelihood
);

  import ycl_pkg::*;

  localparam int unsigned NUM_STAGES = 3 + SQRT_STAGES + 1;
  localparam int unsigned OUT_STAGE  = NUM_STAGES - 1;

  // Configuration registers.
  logic [7:0] target_luma_r;
  logic [7:0] target_blue_chroma_r;
  logic [7:0] target_red_chroma_r;
  mode_t      distance_mode_r;
  logic [7:0] luma_gate_r;

  // Pipeline control: one valid bit per stage and the advance enables.
  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] adv;

  // Stage payloads.
  st_absdiff_t st1_r;
  st_square_t  st2_r;
  st_sum_t     st3_r;
  sqrt_t       sq_r [SQRT_STAGES];
  side_t       sd_r [SQRT_STAGES];
  logic [7:0]  likelihood_r;

  // --------------------------------------------------------------------------
  // Configuration writes. Indexes beyond the register list are ignored.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_luma_r        <= RST_TARGET_LUMA;
      target_blue_chroma_r <= RST_TARGET_BLUE_CHROMA;
      target_red_chroma_r  <= RST_TARGET_RED_CHROMA;
      distance_mode_r      <= RST_DISTANCE_MODE;
      luma_gate_r          <= RST_LUMA_GATE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TARGET_LUMA:        target_luma_r        <= cfg_wdata;
        REG_TARGET_BLUE_CHROMA: target_blue_chroma_r <= cfg_wdata;
        REG_TARGET_RED_CHROMA:  target_red_chroma_r  <= cfg_wdata;
        REG_DISTANCE_MODE:      distance_mode_r      <= cfg_wdata[1:0];
        REG_LUMA_GATE:          luma_gate_r          <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake. A stage may load when it is empty or when its contents move
  // on in the same cycle; the output stage moves when the consumer takes it.
  // --------------------------------------------------------------------------
  always_comb begin
    adv[OUT_STAGE] = !vld_r[OUT_STAGE] || out_ready;
    for (int k = OUT_STAGE - 1; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (adv[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: absolute channel differences and the luma gate test.
  // --------------------------------------------------------------------------
  function automatic logic [7:0] abs_diff(logic [7:0] a, logic [7:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  st_absdiff_t st1_nxt;

  always_comb begin
    st1_nxt.ady            = abs_diff(in_luma, target_luma_r);
    st1_nxt.adb            = abs_diff(in_blue_chroma, target_blue_chroma_r);
    st1_nxt.adr            = abs_diff(in_red_chroma, target_red_chroma_r);
    st1_nxt.side.mode      = distance_mode_r;
    st1_nxt.side.gate_fail = st1_nxt.ady > luma_gate_r;
    st1_nxt.side.sat       = 1'b0;
    st1_nxt.side.l1_half   = '0;
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      st1_r <= st1_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: squares of the differences and the halved chroma L1 distance.
  // --------------------------------------------------------------------------
  st_square_t st2_nxt;
  logic [8:0] l1_sum;

  always_comb begin
    l1_sum               = {1'b0, st1_r.adb} + {1'b0, st1_r.adr};
    st2_nxt.ysq          = st1_r.ady * st1_r.ady;
    st2_nxt.bsq          = st1_r.adb * st1_r.adb;
    st2_nxt.rsq          = st1_r.adr * st1_r.adr;
    st2_nxt.side         = st1_r.side;
    st2_nxt.side.l1_half = l1_sum[8:1];
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      st2_r <= st2_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: sum of squares. Any sum of 2^16 or more has a root of at least
  // 256, which clamps to a likelihood of zero in both euclidean modes, so
  // only the low 16 bits go on to the square root.
  // --------------------------------------------------------------------------
  st_sum_t     st3_nxt;
  logic [17:0] sum_all;
  logic [17:0] sum_sel;

  always_comb begin
    sum_all = {2'b00, st2_r.ysq} + {2'b00, st2_r.bsq} + {2'b00, st2_r.rsq};
    if (st2_r.side.mode == MODE_GATED_CHROMA) begin
      sum_sel = {2'b00, st2_r.bsq} + {2'b00, st2_r.rsq};
    end else begin
      sum_sel = sum_all;
    end
    st3_nxt.n        = sum_sel[15:0];
    st3_nxt.side     = st2_r.side;
    st3_nxt.side.sat = |sum_sel[17:16];
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      st3_r <= st3_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stages 4 to 7: square root, two result bits per stage, most significant
  // first. The remainder left at the end tells whether the root was exact.
  // --------------------------------------------------------------------------
  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
    sqrt_t s_in;
    sqrt_t s_mid;
    sqrt_t s_out;
    side_t side_in;

    if (k == 0) begin : g_first
      assign s_in    = '{rem: st3_r.n, root: 8'd0};
      assign side_in = st3_r.side;
    end else begin : g_next
      assign s_in    = sq_r[k-1];
      assign side_in = sd_r[k-1];
    end

    assign s_mid = sqrt_step(s_in, 3'(7 - 2 * k));
    assign s_out = sqrt_step(s_mid, 3'(6 - 2 * k));

    always_ff @(posedge clk) begin
      if (adv[3+k]) begin
        sq_r[k] <= s_out;
        sd_r[k] <= side_in;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 8: likelihood and output register.
  // Mode 0 uses the floor of the root, mode 1 its ceiling; 255 minus the
  // root is simply its complement. Mode 3 has no meaning and scores zero.
  // --------------------------------------------------------------------------
  sqrt_t      sq_fin;
  side_t      sd_fin;
  logic       root_exact;
  logic [7:0] likelihood_nxt;

  assign sq_fin     = sq_r[SQRT_STAGES-1];
  assign sd_fin     = sd_r[SQRT_STAGES-1];
  assign root_exact = (sq_fin.rem == 16'd0);

  always_comb begin
    case (sd_fin.mode)
      MODE_EUCLID_YCBCR: begin
        likelihood_nxt = sd_fin.sat ? 8'd0 : ~sq_fin.root;
      end
      MODE_GATED_CHROMA: begin
        if (sd_fin.gate_fail || sd_fin.sat) begin
          likelihood_nxt = 8'd0;
        end else if (root_exact) begin
          likelihood_nxt = ~sq_fin.root;
        end else if (sq_fin.root == 8'd255) begin
          likelihood_nxt = 8'd0;
        end else begin
          likelihood_nxt = ~sq_fin.root - 8'd1;
        end
      end
      MODE_CHROMA_L1: begin
        likelihood_nxt = ~sd_fin.l1_half;
      end
      default: begin
        likelihood_nxt = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[OUT_STAGE]) begin
      likelihood_r <= likelihood_nxt;
    end
  end

  assign out_valid      = vld_r[OUT_STAGE];
  assign out_likelihood = likelihood_r;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------

  // The input side only stalls once every stage holds an item.
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&vld_r))
    else $error("input stalled while the pipeline has an empty stage");

  // A finished square root leaves a remainder no larger than twice the root.
  a_sqrt_remainder: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[OUT_STAGE-1] |-> ({8'd0, sq_fin.rem} <= {15'd0, sq_fin.root, 1'b0}))
    else $error("square root remainder out of range");

  // A stalled first stage keeps its item and its contents.
  a_stage1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[0] && !adv[0]) |=> (vld_r[0] && $stable(st1_r)))
    else $error("stalled first stage lost or changed its item");

  // An accepted pixel always lands in the first stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> vld_r[0])
    else $error("accepted pixel did not enter the pipeline");

endmodule
